FILE: src/linear_ode_rk4_stepper_macros.svh
// Assertion macros for the RK4 linear ODE stepper
`ifndef LINEAR_ODE_RK4_STEPPER_MACROS_SVH
`define LINEAR_ODE_RK4_STEPPER_MACROS_SVH

// check that cond holds in the same cycle as trig
`define LORK_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// check that cond holds in the cycle after trig
`define LORK_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: src/lors_pkg.sv
// Types and constants shared by the RK4 linear ODE stepper
package lors_pkg;

	localparam int VEC_LEN    = 32;
	localparam int FRAC_BITS  = 28;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;
	localparam int MAT_DEPTH  = VEC_LEN * VEC_LEN;
	localparam int ACC_W      = 42;
	localparam int SUM_W      = 36;
	localparam int DIV_W      = 35;
	localparam int DIV_STEPS  = 7;
	localparam int DIV_ROUNDS = DIV_W / DIV_STEPS;

	localparam logic [31:0]      STEP_RESET = 32'd42949673;
	localparam logic [CNT_W-1:0] LEN_RESET  = 6'd32;
	localparam logic [CNT_W-1:0] LEN_MIN    = 6'd2;
	localparam logic [CNT_W-1:0] LEN_MAX    = 6'd32;
	localparam logic [SUM_W:0]   DIV_BIAS   = 37'd6 << 32;

	localparam logic CFG_STEP = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_MAT   = 2'd0,
		OP_LOAD_STATE = 2'd1,
		OP_ADVANCE    = 2'd2
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SAT,
		ST_KMUL,
		ST_KWR,
		ST_URD,
		ST_UWR,
		ST_FRD,
		ST_FLD,
		ST_FDIV,
		ST_FOUT
	} state_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [IDX_W-1:0]   row_index;
		logic [IDX_W-1:0]   col_index;
		logic signed [31:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   element_index;
		logic signed [31:0] element_value;
		logic               last;
		logic               overflow;
	} out_item_t;

endpackage

FILE: src/lors_ram.sv
// Generic single-write, single-read RAM with registered read
module lors_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/linear_ode_rk4_stepper.sv
// Top level of the RK4 stepper for x' = A x in fixed point
//
// channel   signals                      handshake
// command   start, busy, cmd             taken when start and not busy
// result    result_valid, result         each word valid for a single cycle, no stall
// config    cfg_we, cfg_index, cfg_wdata taken when cfg_we
//
// A load is written into memory when it is taken and does not raise busy. An advance
// for the n elements in use runs every multiply-add in turn through the one shared
// multiplier. busy stays high for the whole advance.
// Reset clears control state only; matrix and vectors hold garbage until loaded.
module linear_ode_rk4_stepper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lors_pkg::in_item_t  cmd,
	output logic                result_valid,
	output lors_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_wdata
);

	lors_pkg::state_t state_q, state_d;

	logic [1:0]                  stage_q;
	logic [lors_pkg::CNT_W-1:0]  i_q, j_q, n_q, len_q;
	logic [31:0]                 step_q;
	logic signed [lors_pkg::ACC_W-1:0] acc_q;
	logic                        v1_q, v2_q;
	logic signed [63:0]          prod_s2;
	logic signed [31:0]          d_q;
	logic [lors_pkg::VEC_LEN-1:0] ovf_q;
	logic [lors_pkg::DIV_W-1:0]  div_q;
	logic [1:0]                  rem_q;
	logic [2:0]                  rnd_q;
	logic                        res_valid_q;
	lors_pkg::out_item_t         res_q;

	logic accept, i_last, j_last;
	logic [lors_pkg::CNT_W-1:0] n_clamp;

	logic signed [31:0] mat_rd, st_rd, si_rd, k_rd;
	logic signed [lors_pkg::SUM_W-1:0] acc_rd;
	logic signed [31:0] src, k_new;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	logic signed [63:0] prod_shift;
	logic [lors_pkg::ACC_W-32:0] acc_hi;
	logic signed [lors_pkg::SUM_W-1:0] k_ext, acc_new;
	logic signed [31:0] addend, x_sat, nx_sat;
	logic signed [32:0] upd_sum, fin_sum;
	logic [lors_pkg::SUM_W:0] biased;
	logic [lors_pkg::DIV_W-1:0] div_n;
	logic [1:0] rem_n;
	logic [2:0] trial;

	logic st_we, mat_we, si_we, kb_we, ab_we;
	logic [lors_pkg::IDX_W-1:0] st_waddr, st_raddr;
	logic signed [31:0] st_wdata;

	assign accept = start && !busy;
	assign busy   = (state_q != lors_pkg::ST_IDLE);
	assign i_last = (i_q == n_q - 6'd1);
	assign j_last = (j_q == n_q - 6'd1);

	always_comb begin
		if (len_q < lors_pkg::LEN_MIN) begin
			n_clamp = lors_pkg::LEN_MIN;
		end else if (len_q > lors_pkg::LEN_MAX) begin
			n_clamp = lors_pkg::LEN_MAX;
		end else begin
			n_clamp = len_q;
		end
	end

	// memories
	assign mat_we = accept && (cmd.opcode == lors_pkg::OP_LOAD_MAT);

	lors_ram #(.WIDTH(32), .DEPTH(lors_pkg::MAT_DEPTH)) u_mat (
		.clk   (clk),
		.we    (mat_we),
		.waddr ({cmd.row_index, cmd.col_index}),
		.wdata (cmd.load_value),
		.raddr ({i_q[lors_pkg::IDX_W-1:0], j_q[lors_pkg::IDX_W-1:0]}),
		.rdata (mat_rd)
	);

	always_comb begin
		if (state_q == lors_pkg::ST_FOUT) begin
			st_we    = 1'b1;
			st_waddr = i_q[lors_pkg::IDX_W-1:0];
			st_wdata = nx_sat;
		end else begin
			st_we    = accept && (cmd.opcode == lors_pkg::OP_LOAD_STATE);
			st_waddr = cmd.row_index;
			st_wdata = cmd.load_value;
		end
		st_raddr = (state_q == lors_pkg::ST_MAC) ? j_q[lors_pkg::IDX_W-1:0]
			: i_q[lors_pkg::IDX_W-1:0];
	end

	lors_ram #(.WIDTH(32), .DEPTH(lors_pkg::VEC_LEN)) u_state (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rd)
	);

	assign si_we = (state_q == lors_pkg::ST_UWR);

	lors_ram #(.WIDTH(32), .DEPTH(lors_pkg::VEC_LEN)) u_stage (
		.clk   (clk),
		.we    (si_we),
		.waddr (i_q[lors_pkg::IDX_W-1:0]),
		.wdata (x_sat),
		.raddr (j_q[lors_pkg::IDX_W-1:0]),
		.rdata (si_rd)
	);

	assign kb_we = (state_q == lors_pkg::ST_KWR);
	assign ab_we = kb_we;

	lors_ram #(.WIDTH(32), .DEPTH(lors_pkg::VEC_LEN)) u_kbuf (
		.clk   (clk),
		.we    (kb_we),
		.waddr (i_q[lors_pkg::IDX_W-1:0]),
		.wdata (k_new),
		.raddr (i_q[lors_pkg::IDX_W-1:0]),
		.rdata (k_rd)
	);

	lors_ram #(.WIDTH(lors_pkg::SUM_W), .DEPTH(lors_pkg::VEC_LEN)) u_incr (
		.clk   (clk),
		.we    (ab_we),
		.waddr (i_q[lors_pkg::IDX_W-1:0]),
		.wdata (acc_new),
		.raddr (i_q[lors_pkg::IDX_W-1:0]),
		.rdata (acc_rd)
	);

	// shared multiplier and datapath
	always_comb begin
		src = (stage_q == 2'd0) ? st_rd : si_rd;
		if (state_q == lors_pkg::ST_KMUL) begin
			mul_a = {1'b0, step_q};
			mul_b = {d_q[31], d_q};
		end else begin
			mul_a = {mat_rd[31], mat_rd};
			mul_b = {src[31], src};
		end
		mul_full   = mul_a * mul_b;
		prod_shift = prod_s2 >>> lors_pkg::FRAC_BITS;
		acc_hi     = acc_q[lors_pkg::ACC_W-1:31];

		k_new = prod_s2[63:32];
		k_ext = {{(lors_pkg::SUM_W-32){k_new[31]}}, k_new};
		if (stage_q == 2'd1 || stage_q == 2'd2) begin
			k_ext = k_ext <<< 1;
		end
		acc_new = (stage_q == 2'd0) ? k_ext : acc_rd + k_ext;

		addend  = (stage_q == 2'd2) ? k_rd : (k_rd >>> 1);
		upd_sum = {st_rd[31], st_rd} + {addend[31], addend};
		if (upd_sum[32] != upd_sum[31]) begin
			x_sat = upd_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			x_sat = upd_sum[31:0];
		end

		fin_sum = {st_rd[31], st_rd} + {div_q[31], div_q[31:0]};
		if (fin_sum[32] != fin_sum[31]) begin
			nx_sat = fin_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			nx_sat = fin_sum[31:0];
		end

		biased = {acc_rd[lors_pkg::SUM_W-1], acc_rd} + lors_pkg::DIV_BIAS;

		div_n = div_q;
		rem_n = rem_q;
		trial = 3'd0;
		for (int s = 0; s < lors_pkg::DIV_STEPS; s++) begin
			trial = {rem_n, div_n[lors_pkg::DIV_W-1]};
			div_n = {div_n[lors_pkg::DIV_W-2:0], trial >= 3'd3};
			rem_n = (trial >= 3'd3) ? 2'(trial - 3'd3) : trial[1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lors_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lors_pkg::ST_IDLE: begin
				if (accept && cmd.opcode == lors_pkg::OP_ADVANCE) begin
					state_d = lors_pkg::ST_MAC;
				end
			end
			lors_pkg::ST_MAC: begin
				if (j_last) begin
					state_d = lors_pkg::ST_DRAIN;
				end
			end
			lors_pkg::ST_DRAIN: begin
				if (!v1_q && !v2_q) begin
					state_d = lors_pkg::ST_SAT;
				end
			end
			lors_pkg::ST_SAT:  state_d = lors_pkg::ST_KMUL;
			lors_pkg::ST_KMUL: state_d = lors_pkg::ST_KWR;
			lors_pkg::ST_KWR: begin
				if (!i_last) begin
					state_d = lors_pkg::ST_MAC;
				end else if (stage_q == 2'd3) begin
					state_d = lors_pkg::ST_FRD;
				end else begin
					state_d = lors_pkg::ST_URD;
				end
			end
			lors_pkg::ST_URD: state_d = lors_pkg::ST_UWR;
			lors_pkg::ST_UWR: state_d = i_last ? lors_pkg::ST_MAC : lors_pkg::ST_URD;
			lors_pkg::ST_FRD: state_d = lors_pkg::ST_FLD;
			lors_pkg::ST_FLD: state_d = lors_pkg::ST_FDIV;
			lors_pkg::ST_FDIV: begin
				if (rnd_q == 3'(lors_pkg::DIV_ROUNDS - 1)) begin
					state_d = lors_pkg::ST_FOUT;
				end
			end
			lors_pkg::ST_FOUT: state_d = i_last ? lors_pkg::ST_IDLE : lors_pkg::ST_FRD;
			default: state_d = lors_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= 2'd0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= lors_pkg::LEN_MAX;
			len_q       <= lors_pkg::LEN_RESET;
			step_q      <= lors_pkg::STEP_RESET;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			ovf_q       <= '0;
			rnd_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lors_pkg::CFG_STEP: step_q <= cfg_wdata;
					lors_pkg::CFG_LEN:  len_q  <= cfg_wdata[lors_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			v1_q        <= (state_q == lors_pkg::ST_MAC);
			v2_q        <= v1_q;
			res_valid_q <= (state_q == lors_pkg::ST_FOUT);
			case (state_q)
				lors_pkg::ST_IDLE: begin
					stage_q <= 2'd0;
					i_q     <= '0;
					j_q     <= '0;
					n_q     <= n_clamp;
					ovf_q   <= '0;
				end
				lors_pkg::ST_MAC: j_q <= j_q + 6'd1;
				lors_pkg::ST_SAT: begin
					if (!((&acc_hi) || !(|acc_hi))) begin
						ovf_q[i_q[lors_pkg::IDX_W-1:0]] <= 1'b1;
					end
				end
				lors_pkg::ST_KWR: begin
					j_q <= '0;
					i_q <= i_last ? '0 : i_q + 6'd1;
				end
				lors_pkg::ST_UWR: begin
					if (upd_sum[32] != upd_sum[31]) begin
						ovf_q[i_q[lors_pkg::IDX_W-1:0]] <= 1'b1;
					end
					i_q <= i_last ? '0 : i_q + 6'd1;
					if (i_last) begin
						stage_q <= stage_q + 2'd1;
					end
				end
				lors_pkg::ST_FLD:  rnd_q <= '0;
				lors_pkg::ST_FDIV: rnd_q <= rnd_q + 3'd1;
				lors_pkg::ST_FOUT: i_q <= i_q + 6'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q || state_q == lors_pkg::ST_KMUL) begin
			prod_s2 <= mul_full[63:0];
		end
		if (state_q == lors_pkg::ST_IDLE || state_q == lors_pkg::ST_KWR) begin
			acc_q <= '0;
		end else if (v2_q) begin
			acc_q <= acc_q + prod_shift[lors_pkg::ACC_W-1:0];
		end
		if (state_q == lors_pkg::ST_SAT) begin
			if ((&acc_hi) || !(|acc_hi)) begin
				d_q <= acc_q[31:0];
			end else begin
				d_q <= acc_q[lors_pkg::ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
			end
		end
		if (state_q == lors_pkg::ST_FLD) begin
			div_q <= biased[lors_pkg::DIV_W:1];
			rem_q <= 2'd0;
		end else if (state_q == lors_pkg::ST_FDIV) begin
			div_q <= div_n;
			rem_q <= rem_n;
		end
		if (state_q == lors_pkg::ST_FOUT) begin
			res_q.element_index <= i_q[lors_pkg::IDX_W-1:0];
			res_q.element_value <= nx_sat;
			res_q.last          <= i_last;
			res_q.overflow      <= ovf_q[i_q[lors_pkg::IDX_W-1:0]]
				|| (fin_sum[32] != fin_sum[31]);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`include "linear_ode_rk4_stepper_macros.svh"

	`LORK_ASSERT_NEXT(a_word_from_fout, clk, arst_n, state_q == lors_pkg::ST_FOUT, result_valid, "result word missing after output state")
	`LORK_ASSERT_NOW(a_last_index, clk, arst_n, result_valid && result.last, result.element_index == n_q[lors_pkg::IDX_W-1:0] - 5'd1, "last word at wrong index")
	`LORK_ASSERT_NOW(a_idle_drained, clk, arst_n, state_q == lors_pkg::ST_IDLE, !v1_q && !v2_q, "multiply pipeline busy while idle")
	`LORK_ASSERT_NOW(a_sat_drained, clk, arst_n, state_q == lors_pkg::ST_SAT, !v1_q && !v2_q, "row sum taken before pipeline drained")

endmodule
